// ----- src/mqp_pkg.sv -----
`timescale 1ns / 1ps

package mqp_pkg;

  // Byte classification codes
  typedef enum logic [2:0] {
    KIND_TYPE  = 3'd0,
    KIND_LEN   = 3'd1,
    KIND_TLEN  = 3'd2,
    KIND_TOPIC = 3'd3,
    KIND_BODY  = 3'd4
  } field_kind_e;

  // Control packet types with special handling
  localparam logic [3:0] TYPE_PUBLISH = 4'd3;
  localparam logic [3:0] TYPE_PINGREQ = 4'd12;

  // Varint limits
  localparam logic [2:0] LEN_GROUP_MAX = 3'd4;
  localparam logic [27:0] PUBLISH_MIN_LEN = 28'd2;

  // Position saturation value
  localparam logic [15:0] INDEX_MAX = 16'hFFFF;

  // Reset value of the buffer limit register
  localparam logic [15:0] MAX_PACKET_BYTES_RST = 16'd256;

  // One classified byte
  typedef struct packed {
    logic [7:0]  byte_value;
    logic [15:0] byte_index;
    logic [3:0]  packet_type;
    logic [3:0]  header_flags;
    field_kind_e field_kind;
    logic [27:0] remaining_length;
    logic [2:0]  length_byte_count;
    logic [15:0] topic_length;
    logic        within_limit;
    logic        last_of_packet;
    logic        malformed;
    logic        ping_reply_due;
  } mqp_result_t;

endpackage

// ----- src/mqp_in_reg.sv -----
`timescale 1ns / 1ps

module mqp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_stall_o,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] byte_q;
  logic       load;

  // Stall while a held byte cannot move on
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !take_i);

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the byte on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ----- src/mqp_parse.sv -----
`timescale 1ns / 1ps

module mqp_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           byte_i,
  input  logic [15:0]          max_packet_bytes_i,
  output mqp_pkg::mqp_result_t result_o
);

  typedef enum logic [2:0] {
    PH_TYPE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_TLEN_HI = 3'd2,
    PH_TLEN_LO = 3'd3,
    PH_TOPIC   = 3'd4,
    PH_BODY    = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] position_q, position_d;
  logic [27:0] accum_q, accum_d;
  logic [2:0]  groups_q, groups_d;
  logic [27:0] body_left_q, body_left_d;
  logic [3:0]  type_q, type_d;
  logic [3:0]  flags_q, flags_d;
  logic [15:0] tlen_q, tlen_d;
  logic [15:0] topic_left_q, topic_left_d;

  logic [15:0]         idx;
  mqp_pkg::field_kind_e kind;
  logic                last;
  logic                bad;
  logic [27:0]         group_shift;
  logic [27:0]         body_dec;
  logic [15:0]         topic_dec;

  // Place the 7-bit group at its weight
  always_comb begin
    case (groups_q[1:0])
      2'd0:    group_shift = {21'd0, byte_i[6:0]};
      2'd1:    group_shift = {14'd0, byte_i[6:0], 7'd0};
      2'd2:    group_shift = {7'd0, byte_i[6:0], 14'd0};
      default: group_shift = {byte_i[6:0], 21'd0};
    endcase
  end

  assign body_dec  = body_left_q - 28'd1;
  assign topic_dec = topic_left_q - 16'd1;

  // Classify the byte and work out the next parser state
  always_comb begin
    phase_d      = phase_q;
    accum_d      = accum_q;
    groups_d     = groups_q;
    body_left_d  = body_left_q;
    type_d       = type_q;
    flags_d      = flags_q;
    tlen_d       = tlen_q;
    topic_left_d = topic_left_q;
    idx          = position_q;
    kind         = mqp_pkg::KIND_TYPE;
    last         = 1'b0;
    bad          = 1'b0;
    case (phase_q)
      PH_LEN: begin
        kind     = mqp_pkg::KIND_LEN;
        accum_d  = accum_q + group_shift;
        groups_d = groups_q + 3'd1;
        if (byte_i[7]) begin
          if (groups_d >= mqp_pkg::LEN_GROUP_MAX) begin
            bad     = 1'b1;
            last    = 1'b1;
            phase_d = PH_TYPE;
          end
        end else if (type_q == mqp_pkg::TYPE_PUBLISH) begin
          if (accum_d < mqp_pkg::PUBLISH_MIN_LEN) begin
            bad     = 1'b1;
            last    = 1'b1;
            phase_d = PH_TYPE;
          end else begin
            body_left_d = accum_d;
            phase_d     = PH_TLEN_HI;
          end
        end else if (accum_d == 28'd0) begin
          last    = 1'b1;
          phase_d = PH_TYPE;
        end else begin
          body_left_d = accum_d;
          phase_d     = PH_BODY;
        end
      end
      PH_TLEN_HI: begin
        kind        = mqp_pkg::KIND_TLEN;
        tlen_d      = {byte_i, 8'd0};
        body_left_d = body_dec;
        phase_d     = PH_TLEN_LO;
      end
      PH_TLEN_LO: begin
        kind         = mqp_pkg::KIND_TLEN;
        tlen_d       = {tlen_q[15:8], byte_i};
        topic_left_d = tlen_d;
        body_left_d  = body_dec;
        if (body_dec == 28'd0) begin
          last    = 1'b1;
          phase_d = PH_TYPE;
        end else if (tlen_d != 16'd0) begin
          phase_d = PH_TOPIC;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_TOPIC: begin
        kind         = mqp_pkg::KIND_TOPIC;
        topic_left_d = topic_dec;
        body_left_d  = body_dec;
        if (body_dec == 28'd0) begin
          last    = 1'b1;
          phase_d = PH_TYPE;
        end else if (topic_dec == 16'd0) begin
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        kind        = mqp_pkg::KIND_BODY;
        body_left_d = body_dec;
        if (body_dec == 28'd0) begin
          last    = 1'b1;
          phase_d = PH_TYPE;
        end
      end
      default: begin
        // Type byte starts a new packet
        idx          = 16'd0;
        type_d       = byte_i[7:4];
        flags_d      = byte_i[3:0];
        accum_d      = 28'd0;
        groups_d     = 3'd0;
        body_left_d  = 28'd0;
        tlen_d       = 16'd0;
        topic_left_d = 16'd0;
        phase_d      = PH_LEN;
      end
    endcase
    position_d = (idx != mqp_pkg::INDEX_MAX) ? idx + 16'd1 : idx;
  end

  // Assemble the result for this byte
  always_comb begin
    result_o.byte_value        = byte_i;
    result_o.byte_index        = idx;
    result_o.packet_type       = type_d;
    result_o.header_flags      = flags_d;
    result_o.field_kind        = kind;
    result_o.remaining_length  = accum_d;
    result_o.length_byte_count = groups_d;
    result_o.topic_length      = ((kind == mqp_pkg::KIND_TOPIC) ||
                                  (kind == mqp_pkg::KIND_BODY) ||
                                  (phase_q == PH_TLEN_LO)) ? tlen_d : 16'd0;
    result_o.within_limit      = (idx < max_packet_bytes_i);
    result_o.last_of_packet    = last;
    result_o.malformed         = bad;
    result_o.ping_reply_due    = last && !bad && (type_d == mqp_pkg::TYPE_PINGREQ);
  end

  // Advance the parser state on each processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TYPE;
      position_q   <= 16'd0;
      accum_q      <= 28'd0;
      groups_q     <= 3'd0;
      body_left_q  <= 28'd0;
      type_q       <= 4'd0;
      flags_q      <= 4'd0;
      tlen_q       <= 16'd0;
      topic_left_q <= 16'd0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      position_q   <= position_d;
      accum_q      <= accum_d;
      groups_q     <= groups_d;
      body_left_q  <= body_left_d;
      type_q       <= type_d;
      flags_q      <= flags_d;
      tlen_q       <= tlen_d;
      topic_left_q <= topic_left_d;
    end
  end

endmodule

// ----- src/mqp_out_reg.sv -----
`timescale 1ns / 1ps

module mqp_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  mqp_pkg::mqp_result_t result_i,
  output logic                 free_o,
  output logic                 valid_o,
  input  logic                 out_stall_i,
  output mqp_pkg::mqp_result_t result_o
);

  logic                 valid_q;
  logic                 valid_d;
  mqp_pkg::mqp_result_t result_q;

  // Accept a new result when empty or when the held one leaves
  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- src/mqtt_packet_receive_parser.sv -----
`timescale 1ns / 1ps

// MQTT receive parser: takes one received byte per transaction and returns one
// classified byte per transaction, in order. Each result carries the byte, its
// index in the packet, the packet type and flags, its kind (type, length,
// topic length, topic, body), the remaining length decoded so far, the topic
// length of a PUBLISH, whether the index lies below max_packet_bytes (written
// through cfg_wr_en_i / cfg_wr_data_i, reset 256; the user must write it only
// while idle, which the block does not enforce), and the end-of-packet,
// malformed and ping-reply marks. A byte passes an input register, the parsing
// logic and a result register; one byte is taken every cycle while out_stall_i
// is low, and throughput is set by the single parser state update per byte.
module mqtt_packet_receive_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  byte_value_o,
  output logic [15:0] byte_index_o,
  output logic [3:0]  packet_type_o,
  output logic [3:0]  header_flags_o,
  output logic [2:0]  field_kind_o,
  output logic [27:0] remaining_length_o,
  output logic [2:0]  length_byte_count_o,
  output logic [15:0] topic_length_o,
  output logic        within_limit_o,
  output logic        last_of_packet_o,
  output logic        malformed_o,
  output logic        ping_reply_due_o
);

  logic [15:0]          max_packet_bytes_q;
  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 out_free;
  logic                 s1_fire;
  mqp_pkg::mqp_result_t parse_result;
  mqp_pkg::mqp_result_t out_result;

  // Hold the buffer limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_packet_bytes_q <= mqp_pkg::MAX_PACKET_BYTES_RST;
    end else if (cfg_wr_en_i) begin
      max_packet_bytes_q <= cfg_wr_data_i;
    end
  end

  assign s1_fire = s1_valid && out_free;

  mqp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (rx_byte_i),
    .in_stall_o (in_stall_o),
    .take_i     (s1_fire),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  mqp_parse u_parse (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .fire_i             (s1_fire),
    .byte_i             (s1_byte),
    .max_packet_bytes_i (max_packet_bytes_q),
    .result_o           (parse_result)
  );

  mqp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_fire),
    .result_i    (parse_result),
    .free_o      (out_free),
    .valid_o     (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  // Unpack the result onto the ports
  assign byte_value_o        = out_result.byte_value;
  assign byte_index_o        = out_result.byte_index;
  assign packet_type_o       = out_result.packet_type;
  assign header_flags_o      = out_result.header_flags;
  assign field_kind_o        = out_result.field_kind;
  assign remaining_length_o  = out_result.remaining_length;
  assign length_byte_count_o = out_result.length_byte_count;
  assign topic_length_o      = out_result.topic_length;
  assign within_limit_o      = out_result.within_limit;
  assign last_of_packet_o    = out_result.last_of_packet;
  assign malformed_o         = out_result.malformed;
  assign ping_reply_due_o    = out_result.ping_reply_due;

  // Input stalls only when the result register is full and blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register could drain");

  // A ping reply only closes a clean PINGREQ
  a_ping_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ping_reply_due_o) |->
      (last_of_packet_o && !malformed_o && packet_type_o == mqp_pkg::TYPE_PINGREQ))
    else $error("ping reply on a byte that does not end a PINGREQ");

  // Malformed packets end on a length byte
  a_bad_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && malformed_o) |->
      (last_of_packet_o && field_kind_o == mqp_pkg::KIND_LEN))
    else $error("malformed mark outside a closing length byte");

  // A type byte opens the packet at index zero
  a_type_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && field_kind_o == mqp_pkg::KIND_TYPE) |->
      (byte_index_o == 16'd0 && remaining_length_o == 28'd0 && !last_of_packet_o))
    else $error("type byte with nonzero index or length");

endmodule

// ----- dv/mqp_byte_checker.sv -----
`timescale 1ns / 1ps

// Watch both channels of the MQTT receive parser, predict the classification
// of every accepted byte and compare it with the result stream in order.
module mqp_byte_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  byte_value_i,
  input  logic [15:0] byte_index_i,
  input  logic [3:0]  packet_type_i,
  input  logic [3:0]  header_flags_i,
  input  logic [2:0]  field_kind_i,
  input  logic [27:0] remaining_length_i,
  input  logic [2:0]  length_byte_count_i,
  input  logic [15:0] topic_length_i,
  input  logic        within_limit_i,
  input  logic        last_of_packet_i,
  input  logic        malformed_i,
  input  logic        ping_reply_due_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [2:0] {
    AWAIT_TYPE,
    IN_LENGTH,
    TLEN_HI,
    TLEN_LO,
    IN_TOPIC,
    IN_BODY
  } parse_phase_e;

  // Predicted parser state
  parse_phase_e parse_phase;
  logic [15:0]  next_index;
  logic [27:0]  len_accum;
  logic [2:0]   len_groups;
  logic [27:0]  body_left;
  logic [3:0]   pkt_type;
  logic [3:0]   pkt_flags;
  logic [15:0]  topic_size;
  logic [15:0]  topic_left;
  logic [15:0]  buf_limit;

  mqp_pkg::mqp_result_t expected_bytes[$];
  int           errors = 0;

  // Classify one byte and advance the predicted state
  function automatic mqp_pkg::mqp_result_t classify_byte(input logic [7:0] b);
    mqp_pkg::mqp_result_t r;
    logic [15:0] idx;
    logic [27:0] grp;
    r = '0;
    r.byte_value = b;
    if (parse_phase == AWAIT_TYPE) begin
      idx        = '0;
      pkt_type   = b[7:4];
      pkt_flags  = b[3:0];
      len_accum  = '0;
      len_groups = '0;
      body_left  = '0;
      topic_size = '0;
      topic_left = '0;
      r.field_kind = mqp_pkg::KIND_TYPE;
      parse_phase  = IN_LENGTH;
    end else begin
      idx = next_index;
      case (parse_phase)
        IN_LENGTH: begin
          r.field_kind = mqp_pkg::KIND_LEN;
          grp        = {21'd0, b[6:0]};
          len_accum  = len_accum + (grp << (7 * len_groups[1:0]));
          len_groups = len_groups + 3'd1;
          if (b[7]) begin
            // a fourth group that still continues is an overlong varint
            if (len_groups >= mqp_pkg::LEN_GROUP_MAX) begin
              r.malformed      = 1'b1;
              r.last_of_packet = 1'b1;
              parse_phase      = AWAIT_TYPE;
            end
          end else if (pkt_type == mqp_pkg::TYPE_PUBLISH) begin
            if (len_accum < mqp_pkg::PUBLISH_MIN_LEN) begin
              r.malformed      = 1'b1;
              r.last_of_packet = 1'b1;
              parse_phase      = AWAIT_TYPE;
            end else begin
              body_left   = len_accum;
              parse_phase = TLEN_HI;
            end
          end else if (len_accum == '0) begin
            r.last_of_packet = 1'b1;
            parse_phase      = AWAIT_TYPE;
          end else begin
            body_left   = len_accum;
            parse_phase = IN_BODY;
          end
        end
        TLEN_HI: begin
          r.field_kind = mqp_pkg::KIND_TLEN;
          topic_size   = {b, 8'd0};
          body_left    = body_left - 28'd1;
          parse_phase  = TLEN_LO;
        end
        TLEN_LO: begin
          r.field_kind = mqp_pkg::KIND_TLEN;
          topic_size   = topic_size | {8'd0, b};
          topic_left   = topic_size;
          body_left    = body_left - 28'd1;
          if (body_left == '0) begin
            r.last_of_packet = 1'b1;
            parse_phase      = AWAIT_TYPE;
          end else begin
            parse_phase = (topic_left != '0) ? IN_TOPIC : IN_BODY;
          end
        end
        IN_TOPIC: begin
          r.field_kind = mqp_pkg::KIND_TOPIC;
          topic_left   = topic_left - 16'd1;
          body_left    = body_left - 28'd1;
          // the body runs out first when the topic claims more than is left
          if (body_left == '0) begin
            r.last_of_packet = 1'b1;
            parse_phase      = AWAIT_TYPE;
          end else if (topic_left == '0) begin
            parse_phase = IN_BODY;
          end
        end
        default: begin
          r.field_kind = mqp_pkg::KIND_BODY;
          body_left    = body_left - 28'd1;
          if (body_left == '0) begin
            r.last_of_packet = 1'b1;
            parse_phase      = AWAIT_TYPE;
          end
        end
      endcase
    end

    // topic length shows from the second topic-length byte on
    if (r.field_kind >= mqp_pkg::KIND_TLEN &&
        !(r.field_kind == mqp_pkg::KIND_TLEN && parse_phase == TLEN_LO))
      r.topic_length = topic_size;
    r.ping_reply_due    = r.last_of_packet && !r.malformed &&
                          pkt_type == mqp_pkg::TYPE_PINGREQ;
    r.byte_index        = idx;
    r.packet_type       = pkt_type;
    r.header_flags      = pkt_flags;
    r.remaining_length  = (r.field_kind == mqp_pkg::KIND_TYPE) ? '0 : len_accum;
    r.length_byte_count = len_groups;
    r.within_limit      = idx < buf_limit;
    next_index = (idx < mqp_pkg::INDEX_MAX) ? idx + 16'd1 : mqp_pkg::INDEX_MAX;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [27:0] want,
                             input logic [27:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mqp_pkg::mqp_result_t want;
    if (!rst_ni) begin
      parse_phase = AWAIT_TYPE;
      next_index  = '0;
      len_accum   = '0;
      len_groups  = '0;
      body_left   = '0;
      pkt_type    = '0;
      pkt_flags   = '0;
      topic_size  = '0;
      topic_left  = '0;
      buf_limit   = mqp_pkg::MAX_PACKET_BYTES_RST;
      expected_bytes.delete();
    end else begin
      if (cfg_wr_en_i) buf_limit = cfg_wr_data_i;

      // compare the result transaction with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $error("result transaction with no byte outstanding: byte_value 0x%0h",
                 byte_value_i);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("byte_value", 28'(want.byte_value), 28'(byte_value_i));
          check_field("byte_index", 28'(want.byte_index), 28'(byte_index_i));
          check_field("packet_type", 28'(want.packet_type), 28'(packet_type_i));
          check_field("header_flags", 28'(want.header_flags), 28'(header_flags_i));
          check_field("field_kind", 28'(want.field_kind), 28'(field_kind_i));
          check_field("remaining_length", want.remaining_length, remaining_length_i);
          check_field("length_byte_count", 28'(want.length_byte_count),
                      28'(length_byte_count_i));
          check_field("topic_length", 28'(want.topic_length), 28'(topic_length_i));
          check_field("within_limit", 28'(want.within_limit), 28'(within_limit_i));
          check_field("last_of_packet", 28'(want.last_of_packet),
                      28'(last_of_packet_i));
          check_field("malformed", 28'(want.malformed), 28'(malformed_i));
          check_field("ping_reply_due", 28'(want.ping_reply_due),
                      28'(ping_reply_due_i));
        end
      end

      // predict the byte transaction accepted at this edge
      if (in_valid_i && !in_stall_i)
        expected_bytes.push_back(classify_byte(rx_byte_i));
    end
    fail_count_o <= errors;
    pending_o    <= expected_bytes.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SEGMENT_BYTES  = 115;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  byte_value;
  logic [15:0] byte_index;
  logic [3:0]  packet_type;
  logic [3:0]  header_flags;
  logic [2:0]  field_kind;
  logic [27:0] remaining_length;
  logic [2:0]  length_byte_count;
  logic [15:0] topic_length;
  logic        within_limit;
  logic        last_of_packet;
  logic        malformed;
  logic        ping_reply_due;

  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  int          items_sent;
  int          quiet_cycles;
  logic [7:0]  pkt[$];

  always #5 clk_i = ~clk_i;

  mqtt_packet_receive_parser dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_wr_en_i         (cfg_wr_en),
    .cfg_wr_data_i       (cfg_wr_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .rx_byte_i           (rx_byte),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .byte_value_o        (byte_value),
    .byte_index_o        (byte_index),
    .packet_type_o       (packet_type),
    .header_flags_o      (header_flags),
    .field_kind_o        (field_kind),
    .remaining_length_o  (remaining_length),
    .length_byte_count_o (length_byte_count),
    .topic_length_o      (topic_length),
    .within_limit_o      (within_limit),
    .last_of_packet_o    (last_of_packet),
    .malformed_o         (malformed),
    .ping_reply_due_o    (ping_reply_due)
  );

  mqp_byte_checker u_byte_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_wr_en_i         (cfg_wr_en),
    .cfg_wr_data_i       (cfg_wr_data),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .rx_byte_i           (rx_byte),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .byte_value_i        (byte_value),
    .byte_index_i        (byte_index),
    .packet_type_i       (packet_type),
    .header_flags_i      (header_flags),
    .field_kind_i        (field_kind),
    .remaining_length_i  (remaining_length),
    .length_byte_count_i (length_byte_count),
    .topic_length_i      (topic_length),
    .within_limit_i      (within_limit),
    .last_of_packet_i    (last_of_packet),
    .malformed_i         (malformed),
    .ping_reply_due_i    (ping_reply_due),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  // Drive the result-side stall; serve a long hold-off when one is requested
  initial begin : result_sink
    int held;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offer one byte, idling at random first; leave valid high afterwards
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_pkt();
    foreach (pkt[i]) push_byte(pkt[i]);
    pkt.delete();
  endtask

  // Append a remaining-length varint, padded with empty groups up to four
  function automatic void append_length(input logic [27:0] len, input int pad);
    int n;
    int last;
    logic [27:0] grp;
    n = 1;
    while (n < 4 && (len >> (7 * n)) != 0) n++;
    n = (n + pad > 4) ? 4 : n + pad;
    last = n - 1;
    for (int i = 0; i < n; i++) begin
      grp = len >> (7 * i);
      pkt.push_back({(i < last), grp[6:0]});
    end
  endfunction

  // Build a packet; a PUBLISH shorter than two bytes stops after its length
  function automatic void build_packet(input logic [7:0] hdr, input int unsigned len,
                                       input int pad, input logic [15:0] tlen);
    int unsigned n;
    pkt.push_back(hdr);
    append_length(28'(len), pad);
    n = len;
    if (hdr[7:4] == mqp_pkg::TYPE_PUBLISH) begin
      if (len < 2) return;
      pkt.push_back(tlen[15:8]);
      pkt.push_back(tlen[7:0]);
      n = len - 2;
    end
    repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic send_random_packet();
    int unsigned pick;
    int unsigned sel;
    int unsigned len;
    int pad;
    logic [7:0]  hdr;
    logic [15:0] tlen;
    pick = $urandom_range(0, 99);
    hdr  = 8'($urandom_range(0, 255));
    pad  = ($urandom_range(0, 99) < 70) ? 0 : int'($urandom_range(1, 3));
    tlen = '0;
    if (pick < 70) begin
      // well-formed packet, weighted toward PUBLISH and PINGREQ
      sel = $urandom_range(0, 9);
      if (sel < 3) hdr[7:4] = mqp_pkg::TYPE_PUBLISH;
      else if (sel == 3) hdr[7:4] = mqp_pkg::TYPE_PINGREQ;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 320) : $urandom_range(0, 24);
      if (hdr[7:4] == mqp_pkg::TYPE_PUBLISH) begin
        len = len + 2;
        sel = $urandom_range(0, 9);
        if (sel < 7) tlen = 16'($urandom_range(0, len - 2));
        else if (sel < 9) tlen = 16'($urandom_range(len - 1, len + 5));
        else tlen = 16'($urandom_range(0, 65535));
      end
      build_packet(hdr, len, pad, tlen);
    end else if (pick < 85) begin
      // broken packet: overlong varint or short PUBLISH
      if ($urandom_range(0, 1) == 1) begin
        pkt.push_back(hdr);
        repeat (4) pkt.push_back({1'b1, 7'($urandom_range(0, 127))});
      end else begin
        hdr[7:4] = mqp_pkg::TYPE_PUBLISH;
        build_packet(hdr, $urandom_range(0, 1), pad, '0);
      end
    end else begin
      // noise; clear bit 7 so no stray varint swallows the stream
      repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(0, 127)));
    end
    send_pkt();
  endtask

  // Drain, let the pipeline settle, then write the buffer limit
  task automatic write_limit(input logic [15:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk_i);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [15:0] limits[6];
    int seg_end;
    rst_ni        = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    rx_byte       = '0;
    send_idle_pct = 10;
    recv_idle_pct = 65;
    hold_req      = 1'b0;
    items_sent    = 0;
    quiet_cycles  = 0;
    limits = '{16'd0, 16'($urandom_range(2, 40)), 16'd1, 16'd300, 16'd7, 16'hFFFF};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed packets under the reset limit
    pkt = '{8'hFF, 8'h00};                                // all-ones type, empty body
    send_pkt();
    pkt = '{8'hC0, 8'h00};                                // empty PINGREQ
    send_pkt();
    pkt = '{8'hC2, 8'h01, 8'h5A};                         // PINGREQ with a body byte
    send_pkt();
    pkt = '{8'h30, 8'h01};                                // short PUBLISH
    send_pkt();
    pkt = '{8'h2A, 8'hFF, 8'hFF, 8'hFF, 8'hFF};           // overlong varint
    send_pkt();
    pkt = '{8'h32, 8'h04, 8'h00, 8'h05, 8'hA1, 8'hB2};    // topic longer than body
    send_pkt();
    pkt = '{8'h35, 8'h03, 8'h00, 8'h00, 8'h7E};           // empty topic
    send_pkt();

    // random packets over three idling patterns, two limits each
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 10 : (p == 1) ? 65 : 0;
      recv_idle_pct = (p == 0) ? 65 : (p == 1) ? 10 : 0;
      for (int s = 0; s < 2; s++) begin
        write_limit(limits[2 * p + s]);
        if (s == 0) hold_req = 1'b1;
        seg_end = items_sent + SEGMENT_BYTES;
        while (items_sent < seg_end) send_random_packet();
      end
    end

    // largest remaining length; the run ends inside its topic
    pkt = '{8'h3A, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h12, 8'h34};
    repeat (3) pkt.push_back(8'($urandom_range(0, 255)));
    send_pkt();

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
